>>> hw/rtl/psv_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// psv_pkg
// Shared constants, codes and types of the plucked-string voice.
// -----------------------------------------------------------------------------
package psv_pkg;

   // Defaults of the top-level parameters
   localparam int DEPTH_DEF       = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths
   localparam int CMD_BITS  = 2;
   localparam int SR_BITS   = 18;
   localparam int FREQ_BITS = 19;
   localparam int AMP_BITS  = 16;
   localparam int LOSS_BITS = 16;

   // Reset values
   localparam int SR_RESET   = 44100;
   localparam int LOSS_RESET = 65339;   // 0.997 in Q0.16
   localparam int RESET_LEN  = 100;

   // Arithmetic constants
   localparam int MIN_LEN    = 8;
   localparam int NOISE_COEF = 29491;     // 0.45 in Q0.16
   localparam int LOSS_BASE  = 31920000;  // 0.9975 scaled, see loss formula
   localparam int LOSS_DIV   = 15625;
   localparam int LOSS_SHIFT = 5;         // times 32
   // 32*x/15625 == (x * LOSS_RECIP) >> LOSS_RECIP_SHIFT, exact for 25-bit x
   localparam int LOSS_RECIP       = 1125899907;  // ceil(2^44 / 15625)
   localparam int LOSS_RECIP_SHIFT = 39;

   // Divider
   localparam int DIV_BITS = 30;
   localparam int DSR_BITS = 19;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK  = 2'd0,
      CMD_PLUCK = 2'd1,
      CMD_FILL  = 2'd2
   } psv_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TICK,
      ST_LEN_DIV
   } psv_state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DSR_BITS-1:0] divisor;
   } psv_div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
   } psv_div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/psv_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// psv_if
// Valid/ready channels of the plucked-string voice: request, response, CSR.
// -----------------------------------------------------------------------------
interface psv_req_if #(
   parameter int SAMPLE_BITS = psv_pkg::SAMPLE_BITS_DEF
);
   logic                                valid;
   logic                                ready;
   logic [psv_pkg::CMD_BITS-1:0]        command;
   logic [psv_pkg::FREQ_BITS-1:0]       freq_hz;
   logic [psv_pkg::AMP_BITS-1:0]        amplitude;
   logic signed [SAMPLE_BITS-1:0]       noise;

   modport source (output valid, command, freq_hz, amplitude, noise, input ready);
   modport sink   (input valid, command, freq_hz, amplitude, noise, output ready);
endinterface

interface psv_rsp_if #(
   parameter int SAMPLE_BITS = psv_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          active;

   modport source (output valid, sample, active, input ready);
   modport sink   (input valid, sample, active, output ready);
endinterface

interface psv_csr_if;
   logic                         valid;
   logic                         ready;
   logic [psv_pkg::SR_BITS-1:0]  sample_rate;

   modport source (output valid, sample_rate, input ready);
   modport sink   (input valid, sample_rate, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plucked_string_voice_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// plucked_string_voice_core
// One Karplus-Strong plucked-string voice in fixed point, loop in a RAM.
// -----------------------------------------------------------------------------
// The voice keeps its delay loop in a DEPTH-entry RAM (one write port, two
// registered read ports). After reset the RAM is swept to zero, one entry per
// cycle, over all DEPTH entries (4096 at the default); req_chan.ready stays low
// for that time while CSR writes are taken as usual. Afterwards: a fill item
// low-pass filters the noise and writes it to the loop while room is left; a
// tick reads the current and next loop entries into the read registers, then
// writes back and loads the response register, waiting while that register is
// full and rsp_chan.ready is low; a pluck runs the bit-serial divider that
// finds the loop length (sample_rate*16 / freq_hz); the loop loss comes from a
// constant reciprocal multiply and is loaded with the length. Command 3 is
// consumed with no response. Only ticks return a response; sample is
// saturated Q1.(SAMPLE_BITS-1), 0 with active low until the first pluck.
// csr_chan is always ready; write it only while idle.
// -----------------------------------------------------------------------------
module plucked_string_voice_core
   import psv_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   psv_req_if.sink     req_chan,
   psv_rsp_if.source   rsp_chan,
   psv_csr_if.sink     csr_chan
);

   localparam int SB      = SAMPLE_BITS;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int LEN_W   = IDX_W + 1;            // holds DEPTH itself
   localparam int LEN_RST = (RESET_LEN < DEPTH) ? RESET_LEN : DEPTH;
   localparam int PW      = SB + 18;              // product width, tick and fill

   localparam logic signed [PW-1:0] RND16 = PW'(1) <<< 15;
   localparam logic signed [PW-1:0] RND17 = PW'(1) <<< 16;
   localparam logic signed [PW-1:0] RND15 = PW'(1) <<< 14;
   localparam logic signed [16:0]   COEF  = 17'(NOISE_COEF);

   // ---------------------------------------------------------------- state
   psv_state_type          state_ff, state_in;
   logic [IDX_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]       ri_ff, ri_in;           // read index
   logic [LEN_W-1:0]       len_ff, len_in;         // loop length
   logic [LEN_W-1:0]       fp_ff, fp_in;           // fill pointer
   logic signed [SB-1:0]   nf_ff, nf_in;           // noise low-pass state
   logic [AMP_BITS-1:0]    gain_ff, gain_in;
   logic [LOSS_BITS-1:0]   loss_ff, loss_in;
   logic                   playing_ff, playing_in;
   logic [SR_BITS-1:0]     sr_ff, sr_in;
   logic [FREQ_BITS-1:0]   freq_ff, freq_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]   rsp_sample_ff, rsp_sample_in;
   logic                   rsp_active_ff, rsp_active_in;

   // ---------------------------------------------------------------- loop RAM
   logic signed [SB-1:0]   store_mem [DEPTH];
   logic signed [SB-1:0]   rd_c_ff, rd_m_ff;       // current and next entry
   logic                   rd_en;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic signed [SB-1:0]   wr_data;

   psv_div_req_type        div_req;
   psv_div_rsp_type        div_rsp;

   logic                   accept;
   logic                   slot_free;
   logic                   fill_room;
   logic                   rsp_load;
   logic [LEN_W-1:0]       ri_inc;
   logic [IDX_W-1:0]       nxt_idx;
   logic [LEN_W-1:0]       len_clamp;
   logic [22:0]            freq_x9;
   logic [24:0]            loss_num;
   logic [55:0]            loss_prod;

   // fill datapath
   logic signed [SB:0]     fill_diff;
   logic signed [PW-1:0]   fill_prod;
   logic signed [PW-1:0]   fill_step;
   logic signed [PW-1:0]   fill_sum;
   logic signed [SB-1:0]   fill_val;

   // tick datapath
   logic signed [SB:0]     cm_sum;
   logic signed [16:0]     loss_s;
   logic signed [16:0]     gain_s;
   logic signed [PW-1:0]   wb_prod;
   logic signed [PW-1:0]   wb_shf;
   logic signed [SB-1:0]   wb_val;
   logic signed [PW-1:0]   out_prod;
   logic signed [PW-1:0]   out_shf;
   logic signed [SB-1:0]   out_val;

   assign accept    = req_chan.valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign fill_room = fp_ff < len_ff;

   // next loop position, wraps at the loop length
   assign ri_inc  = {1'b0, ri_ff} + 1'b1;
   assign nxt_idx = (ri_inc == len_ff) ? '0 : ri_inc[IDX_W-1:0];

   // Pluck length: zero frequency gives the full loop, else clamp to [8, DEPTH]
   always_comb begin
      if (freq_ff == '0) begin
         len_clamp = LEN_W'(DEPTH);
      end else if (div_rsp.quotient < DIV_BITS'(MIN_LEN)) begin
         len_clamp = LEN_W'(MIN_LEN);
      end else if (div_rsp.quotient > DIV_BITS'(DEPTH)) begin
         len_clamp = LEN_W'(DEPTH);
      end else begin
         len_clamp = div_rsp.quotient[LEN_W-1:0];
      end
   end

   // Loss numerator 31920000 - 9f; 9f never reaches the base for 19-bit f
   assign freq_x9  = {freq_ff, 3'b000} + {4'b0000, freq_ff};
   assign loss_num = 25'(LOSS_BASE) - {2'b00, freq_x9};
   // loss = floor(32 * num / 15625) by reciprocal multiply
   assign loss_prod = {31'b0, loss_num} * 56'(LOSS_RECIP);

   // Fill: nf += round(0.45 * (noise - nf)), ties up, saturated
   always_comb begin
      fill_diff = {req_chan.noise[SB-1], req_chan.noise} - {nf_ff[SB-1], nf_ff};
      fill_prod = fill_diff * COEF;
      fill_step = (fill_prod + RND16) >>> 16;
      fill_sum  = PW'(nf_ff) + fill_step;
      if (&fill_sum[PW-1:SB-1] || ~|fill_sum[PW-1:SB-1]) begin
         fill_val = fill_sum[SB-1:0];
      end else begin
         fill_val = {fill_sum[PW-1], {(SB-1){~fill_sum[PW-1]}}};
      end
   end

   // Tick: write-back round((c+m)*loss / 2^17), output round(c*gain / 2^15)
   always_comb begin
      cm_sum   = {rd_c_ff[SB-1], rd_c_ff} + {rd_m_ff[SB-1], rd_m_ff};
      loss_s   = {1'b0, loss_ff};
      gain_s   = {1'b0, gain_ff};
      wb_prod  = cm_sum * loss_s;
      wb_shf   = (wb_prod + RND17) >>> 17;
      out_prod = rd_c_ff * gain_s;
      out_shf  = (out_prod + RND15) >>> 15;
      if (&wb_shf[PW-1:SB-1] || ~|wb_shf[PW-1:SB-1]) begin
         wb_val = wb_shf[SB-1:0];
      end else begin
         wb_val = {wb_shf[PW-1], {(SB-1){~wb_shf[PW-1]}}};
      end
      if (&out_shf[PW-1:SB-1] || ~|out_shf[PW-1:SB-1]) begin
         out_val = out_shf[SB-1:0];
      end else begin
         out_val = {out_shf[PW-1], {(SB-1){~out_shf[PW-1]}}};
      end
   end

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == IDX_W'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.command == CMD_TICK) begin
                  state_in = ST_TICK;
               end else if (req_chan.command == CMD_PLUCK) begin
                  state_in = ST_LEN_DIV;
               end
            end
         end
         ST_TICK: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_LEN_DIV: begin
            if (div_rsp.done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rsp_load = 1'b0;
      div_req  = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.command)
                  CMD_TICK: begin
                     rd_en = 1'b1;
                  end
                  CMD_PLUCK: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = {{(DIV_BITS - SR_BITS - 4){1'b0}}, sr_ff, 4'b0000};
                     div_req.divisor  = req_chan.freq_hz;
                  end
                  CMD_FILL: begin
                     wr_en   = fill_room;
                     wr_addr = fp_ff[IDX_W-1:0];
                     wr_data = fill_val;
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               wr_en    = playing_ff;
               wr_addr  = ri_ff;
               wr_data  = wb_val;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- next values
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      ri_in         = ri_ff;
      len_in        = len_ff;
      fp_in         = fp_ff;
      nf_in         = nf_ff;
      gain_in       = gain_ff;
      loss_in       = loss_ff;
      playing_in    = playing_ff;
      freq_in       = freq_ff;
      sr_in         = sr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_active_in = rsp_active_ff;

      if (state_ff == ST_CLEAR) clr_cnt_in = clr_cnt_ff + 1'b1;

      if (accept && (req_chan.command == CMD_PLUCK)) begin
         gain_in    = req_chan.amplitude;
         freq_in    = req_chan.freq_hz;
         ri_in      = '0;
         fp_in      = '0;
         nf_in      = '0;
         playing_in = 1'b1;
      end

      if (accept && (req_chan.command == CMD_FILL)) begin
         nf_in = fill_val;
         if (fill_room) fp_in = fp_ff + 1'b1;
      end

      if (rsp_load && playing_ff) ri_in = nxt_idx;

      if ((state_ff == ST_LEN_DIV) && div_rsp.done) begin
         len_in  = len_clamp;
         loss_in = loss_prod[LOSS_RECIP_SHIFT +: LOSS_BITS];
      end

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = playing_ff ? out_val : '0;
         rsp_active_in = playing_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_chan.valid) sr_in = csr_chan.sample_rate;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ri_ff        <= '0;
         len_ff       <= LEN_W'(LEN_RST);
         fp_ff        <= '0;
         nf_ff        <= '0;
         gain_ff      <= '0;
         loss_ff      <= LOSS_BITS'(LOSS_RESET);
         playing_ff   <= 1'b0;
         sr_ff        <= SR_BITS'(SR_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ri_ff        <= ri_in;
         len_ff       <= len_in;
         fp_ff        <= fp_in;
         nf_ff        <= nf_in;
         gain_ff      <= gain_in;
         loss_ff      <= loss_in;
         playing_ff   <= playing_in;
         sr_ff        <= sr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff       <= freq_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_active_ff <= rsp_active_in;
   end

   // loop RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         rd_c_ff <= store_mem[ri_ff];
         rd_m_ff <= store_mem[nxt_idx];
      end
   end

   psv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------- ports
   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = rsp_sample_ff;
   assign rsp_chan.active = rsp_active_ff;

endmodule

`default_nettype wire

>>> hw/rtl/psv_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// psv_div
// Restoring divider, one quotient bit per cycle, used by the pluck setup.
// -----------------------------------------------------------------------------
module psv_div
   import psv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire psv_div_req_type  div_req,
   output psv_div_rsp_type       div_rsp
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DSR_BITS-1:0]     rem_ff, rem_in;
   logic [DSR_BITS-1:0]     dsr_ff, dsr_in;
   logic [DSR_BITS:0]       rem_sh;
   logic [DSR_BITS:0]       rem_sub;
   logic                    ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_BITS-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIV_BITS - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops
         rem_in = ge ? rem_sub[DSR_BITS-1:0] : rem_sh[DSR_BITS-1:0];
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/psv_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// psv_checker
// Port-level checks of the plucked-string voice, bound to the top level.
// -----------------------------------------------------------------------------
module psv_checker
   import psv_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic [CMD_BITS-1:0]    req_command,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [SAMPLE_BITS-1:0] rsp_sample,
   input wire logic                   rsp_active
);

   // RAM clear runs right after reset: no item taken then
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("item accepted during loop clear");

   // pluck setup keeps the request side closed
   a_pluck_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == CMD_PLUCK)) |=> !req_ready)
      else $error("request ready during pluck setup");

   // silent voice gives zero samples
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_sample == '0))
      else $error("nonzero sample from idle voice");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("stalled response changed");

endmodule

bind plucked_string_voice_core psv_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_psv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_sample  (rsp_chan.sample),
   .rsp_active  (rsp_chan.active)
);

`default_nettype wire
